[hdl/sipd_pkg.sv]
// package for the signed decimal formatter
// types, codes and constants shared by controller and datapath
`timescale 1ns / 1ps
`default_nettype none

package sipd_pkg;

    localparam int NUM_DIGITS = 5;
    localparam int DIG_IDX_W = 3;

    // reciprocal of ten, exact for every 16-bit magnitude
    localparam logic [15:0] RECIP_TEN = 16'd52429;
    localparam int RECIP_SHIFT = 19;

    localparam logic [7:0] CHR_ZERO = 8'h30;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_MINUS = 8'h2D;

    localparam logic KIND_POS = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_POS,
        ST_PAD,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    typedef enum logic [1:0] {
        SEL_POS,
        SEL_SPACE,
        SEL_MINUS,
        SEL_DIGIT
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      step;
        logic      prep;
        logic      emit;
        emit_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic slot_free;
        logic pad_zero;
        logic pad_one;
        logic neg;
        logic dig_one;
    } status_t;

endpackage

`default_nettype wire

[hdl/sipd_ctrl.sv]
// controller state machine for the signed decimal formatter
// depends on sipd_pkg; drives the datapath through cmd_t, reads status_t
`timescale 1ns / 1ps
`default_nettype none

module sipd_ctrl
    import sipd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '{load: 1'b0, step: 1'b0, prep: 1'b0, emit: 1'b0, sel: SEL_POS};
        in_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (status.conv_done)
                begin
                    cmd.prep = 1'b1;
                    state_next = ST_POS;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_POS:
            begin
                cmd.sel = SEL_POS;
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (!status.pad_zero)
                    begin
                        state_next = ST_PAD;
                    end
                    else if (status.neg)
                    begin
                        state_next = ST_SIGN;
                    end
                    else
                    begin
                        state_next = ST_DIGIT;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.sel = SEL_SPACE;
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.pad_one)
                    begin
                        state_next = status.neg ? ST_SIGN : ST_DIGIT;
                    end
                end
            end
            ST_SIGN:
            begin
                cmd.sel = SEL_MINUS;
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                cmd.sel = SEL_DIGIT;
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.dig_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/sipd_datapath.sv]
// datapath for the signed decimal formatter: magnitude, digit extraction,
// pad and digit counters, output register; depends on sipd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sipd_datapath
    import sipd_pkg::*;
#(
    parameter int MAX_WIDTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        line,
    input  wire logic [3:0]  column,
    input  wire logic [15:0] value,
    input  wire logic [4:0]  field_width,
    input  wire cmd_t        cmd,
    output status_t          status,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic             out_line,
    output logic [3:0]       out_column,
    output logic [7:0]       character,
    output logic             last
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > 5) ? WW : 5;

    logic [15:0]          mag_reg;
    logic                 neg_reg;
    logic                 line_reg;
    logic [3:0]           col_reg;
    logic [WW-1:0]        width_reg;
    logic [DIG_IDX_W-1:0] ndig_reg;
    logic [DIG_IDX_W-1:0] dig_idx_reg;
    logic [WW-1:0]        pad_reg;
    logic [3:0]           digit_reg [NUM_DIGITS];

    logic                 out_valid_reg;
    logic                 kind_reg;
    logic                 out_line_reg;
    logic [3:0]           out_col_reg;
    logic [7:0]           char_reg;
    logic                 last_reg;

    logic [CW-1:0]        fw_ext;
    logic [WW-1:0]        width_sat;
    logic [31:0]          prod;
    logic [15:0]          quot;
    logic [15:0]          quot_x10;
    logic [3:0]           rem;
    logic [WW-1:0]        len_w;
    logic [DIG_IDX_W-1:0] rd_idx;
    logic [7:0]           char_next;

    assign fw_ext = CW'(field_width);
    assign width_sat = (fw_ext > CW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw_ext);

    // divide by ten with a reciprocal multiply
    assign prod = mag_reg * RECIP_TEN;
    assign quot = 16'(prod >> RECIP_SHIFT);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem = 4'(mag_reg - quot_x10);

    assign len_w = WW'(ndig_reg) + WW'(neg_reg);
    assign rd_idx = dig_idx_reg - DIG_IDX_W'(1);

    always_comb
    begin
        case (cmd.sel)
            SEL_SPACE: char_next = CHR_SPACE;
            SEL_MINUS: char_next = CHR_MINUS;
            SEL_DIGIT: char_next = CHR_ZERO + 8'(digit_reg[rd_idx]);
            default:   char_next = 8'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg <= value[15];
            mag_reg <= value[15] ? 16'(-value) : value;
            line_reg <= line;
            col_reg <= column;
            width_reg <= width_sat;
        end
        else if (cmd.step)
        begin
            mag_reg <= quot;
            digit_reg[ndig_reg] <= rem;
        end
        if (cmd.prep)
        begin
            pad_reg <= (width_reg > len_w) ? width_reg - len_w : '0;
        end
        else if (cmd.emit && cmd.sel == SEL_SPACE)
        begin
            pad_reg <= pad_reg - WW'(1);
        end
        if (cmd.emit)
        begin
            kind_reg <= (cmd.sel == SEL_POS) ? KIND_POS : KIND_CHAR;
            out_line_reg <= (cmd.sel == SEL_POS) ? line_reg : 1'b0;
            out_col_reg <= (cmd.sel == SEL_POS) ? col_reg : 4'd0;
            char_reg <= char_next;
            last_reg <= (cmd.sel == SEL_DIGIT) && (dig_idx_reg == DIG_IDX_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ndig_reg <= '0;
            dig_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                ndig_reg <= '0;
            end
            else if (cmd.step)
            begin
                ndig_reg <= ndig_reg + DIG_IDX_W'(1);
            end
            if (cmd.prep)
            begin
                dig_idx_reg <= ndig_reg;
            end
            else if (cmd.emit && cmd.sel == SEL_DIGIT)
            begin
                dig_idx_reg <= rd_idx;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.conv_done = (ndig_reg != '0)
                           && ((mag_reg == 16'd0) || (ndig_reg == DIG_IDX_W'(NUM_DIGITS)));
        status.slot_free = !out_valid_reg || !out_stall;
        status.pad_zero = (pad_reg == '0);
        status.pad_one = (pad_reg == WW'(1));
        status.neg = neg_reg;
        status.dig_one = (dig_idx_reg == DIG_IDX_W'(1));
    end

    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign out_line = out_line_reg;
    assign out_column = out_col_reg;
    assign character = char_reg;
    assign last = last_reg;

endmodule

`default_nettype wire

[hdl/signed_int_to_padded_decimal.sv]
// top level of the signed decimal formatter
// instantiates sipd_ctrl and sipd_datapath; depends on sipd_pkg
//
// input channel: in_valid / in_stall with line, column, value, field_width.
// one number is taken at a time; in_stall is high from the cycle after an
// accept until the number's last character has entered the output register.
// output channel: out_valid / out_stall with kind, out_line, out_column,
// character, last. each number gives one cursor position item, then spaces
// for right alignment, a minus if negative, and the digits, last marked.
// timing: decimal digits come from a reciprocal multiply by ten, one per
// cycle, then a step sizes the padding; results then leave one per cycle
// through the single output register while the receiver does not stall.
// a new number is taken while the last character still waits in the output
// register. a stalled receiver freezes the output register and holds the
// sequencer in its emit states; nothing is dropped.
// reset clears the state machine and the output valid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_padded_decimal
    import sipd_pkg::*;
#(
    parameter int MAX_WIDTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        line,
    input  wire logic [3:0]  column,
    input  wire logic [15:0] value,
    input  wire logic [4:0]  field_width,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic             out_line,
    output logic [3:0]       out_column,
    output logic [7:0]       character,
    output logic             last
);

    cmd_t    cmd;
    status_t status;

    sipd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sipd_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .line        (line),
        .column      (column),
        .value       (value),
        .field_width (field_width),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_line    (out_line),
        .out_column  (out_column),
        .character   (character),
        .last        (last)
    );

endmodule

`default_nettype wire

[hdl/sipd_checker.sv]
// port-level checks for the signed decimal formatter
// bound to signed_int_to_padded_decimal; depends on sipd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sipd_checker
    import sipd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       kind,
    input wire logic       out_line,
    input wire logic [3:0] out_column,
    input wire logic [7:0] character,
    input wire logic       last
);

    // output valid, character and kind are held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(character) && $stable(kind))
        else $error("stalled output item changed");

    // one number at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a number is in progress");

    // position item carries no character and no last mark
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_POS |-> character == 8'd0 && !last)
        else $error("position item with character data");

    // character items carry no position
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_CHAR |-> !out_line && out_column == 4'd0)
        else $error("character item with position data");

endmodule

bind signed_int_to_padded_decimal sipd_checker u_sipd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .out_line   (out_line),
    .out_column (out_column),
    .character  (character),
    .last       (last)
);

`default_nettype wire

[tb/tb_signed_int_to_padded_decimal.sv]
// testbench for signed_int_to_padded_decimal: a scoreboard class rebuilds the
// right-aligned decimal text of every accepted number and checks the output items
// depends on sipd_pkg and the signed_int_to_padded_decimal top level
`timescale 1ns / 1ps

module tb_signed_int_to_padded_decimal;
    import sipd_pkg::*;

    localparam int MAX_W = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic       kind;
        logic       ln;
        logic [3:0] col;
        logic [7:0] chr;
        logic       lst;
    } disp_item_t;

    class display_scoreboard;
        disp_item_t text_q[$];
        int errors = 0;

        function void note_number(logic ln, logic [3:0] col, logic [15:0] val,
                                  logic [4:0] fw);
            logic neg;
            logic [16:0] mag;
            logic [3:0] digs [5];
            int nd;
            int len;
            int w;
            neg = val[15];
            mag = neg ? 17'h10000 - {1'b0, val} : {1'b0, val};
            w = (fw > MAX_W) ? MAX_W : int'(fw);
            nd = 0;
            do begin
                digs[nd] = 4'(mag % 10);
                nd++;
                mag = mag / 10;
            end while (mag != 0 && nd < 5);
            len = nd + (neg ? 1 : 0);
            text_q.push_back('{KIND_POS, ln, col, 8'h00, 1'b0});
            for (int i = 0; i < w - len; i++)
                text_q.push_back('{KIND_CHAR, 1'b0, 4'h0, CHR_SPACE, 1'b0});
            if (neg)
                text_q.push_back('{KIND_CHAR, 1'b0, 4'h0, CHR_MINUS, 1'b0});
            for (int i = nd; i > 0; i--)
                text_q.push_back('{KIND_CHAR, 1'b0, 4'h0, CHR_ZERO + 8'(digs[i - 1]),
                                   (i == 1)});
        endfunction

        function void check_item(disp_item_t got);
            disp_item_t want;
            if (text_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected item: kind=%0d line=%0d col=%0d char=%02h last=%0d",
                             got.kind, got.ln, got.col, got.chr, got.lst);
                return;
            end
            want = text_q.pop_front();
            if (got.kind !== want.kind || got.ln !== want.ln || got.col !== want.col ||
                got.chr !== want.chr || got.lst !== want.lst) begin
                errors++;
                if (errors <= REPORT_MAX) begin
                    $display("mismatch: expected kind=%0d line=%0d col=%0d char=%02h last=%0d",
                             want.kind, want.ln, want.col, want.chr, want.lst);
                    $display("               got kind=%0d line=%0d col=%0d char=%02h last=%0d",
                             got.kind, got.ln, got.col, got.chr, got.lst);
                end
            end
        endfunction

        function int outstanding();
            return text_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        line;
    logic [3:0]  column;
    logic [15:0] value;
    logic [4:0]  field_width;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic        out_line;
    logic [3:0]  out_column;
    logic [7:0]  character;
    logic        last;

    display_scoreboard board = new();
    int idle_pct = 25;
    int rx_burst = 0;
    int cycle_count = 0;
    logic hold_go = 1'b0;
    logic hold_rx = 1'b0;

    signed_int_to_padded_decimal dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .line        (line),
        .column      (column),
        .value       (value),
        .field_width (field_width),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_line    (out_line),
        .out_column  (out_column),
        .character   (character),
        .last        (last)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_item('{kind, out_line, out_column, character, last});
        if (rx_burst > 0)
            rx_burst--;
        else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            rx_burst = $urandom_range(1, 5);
        out_stall <= hold_rx || (rx_burst > 0);
    end

    // long receiver hold-off so the input side backs up
    initial
    begin
        wait (hold_go);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_number(input int ln, input int col, input int val, input int fw);
        int gap;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        line        <= ln[0];
        column      <= col[3:0];
        value       <= val[15:0];
        field_width <= fw[4:0];
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        board.note_number(line, column, value, field_width);
    endtask

    function automatic int pick_value();
        int p;
        case ($urandom_range(0, 5))
            2: return int'($urandom_range(0, 40)) - 20;
            3:
            begin
                p = 1;
                repeat ($urandom_range(1, 4)) p = p * 10;
                if ($urandom_range(0, 1))
                    p = p - 1;
                return $urandom_range(0, 1) ? p : -p;
            end
            4:
            begin
                case ($urandom_range(0, 3))
                    0: return 32767;
                    1: return -32768;
                    2: return -32767;
                    default: return 0;
                endcase
            end
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    task automatic send_random();
        int fw;
        fw = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
        send_number($urandom_range(0, 1), $urandom_range(0, 15), pick_value(), fw);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.outstanding() != 0);
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        out_stall   <= 1'b0;
        line        <= 1'b0;
        column      <= 4'h0;
        value       <= 16'h0000;
        field_width <= 5'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, extremes, digit-count boundaries, narrow and saturated widths
        send_number(0, 0, 0, 0);
        send_number(1, 15, 0, 1);
        send_number(0, 3, 0, 16);
        send_number(1, 0, 32767, 0);
        send_number(0, 15, 32767, 16);
        send_number(1, 7, -32768, 0);
        send_number(0, 1, -32768, 6);
        send_number(1, 2, -32768, 16);
        send_number(0, 4, -32768, 31);
        send_number(1, 5, -1, 2);
        send_number(0, 6, 9, 3);
        send_number(1, 8, 10, 1);
        send_number(0, 9, 99, 4);
        send_number(1, 10, -100, 5);
        send_number(0, 11, 999, 7);
        send_number(1, 12, -1000, 10);
        send_number(0, 13, 9999, 12);
        send_number(1, 14, 10000, 15);
        send_number(0, 0, -10, 17);
        send_number(1, 1, 5, 31);
        send_number(0, 2, 12345, 3);
        send_number(1, 3, -32767, 20);

        for (int i = 0; i < 90; i++)
        begin
            if (i % 30 == 0)
                idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
            send_random();
        end

        idle_pct = 25;
        hold_go <= 1'b1;
        for (int i = 0; i < 25; i++)
            send_random();

        wait_drained();
        for (int i = 0; i < 90; i++)
        begin
            if (i % 30 == 0)
                idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
            send_random();
        end

        idle_pct = 0;
        for (int i = 0; i < 40; i++)
            send_random();

        wait_drained();
        repeat (30) @(posedge clk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[signed_int_to_padded_decimal.f]
hdl/sipd_pkg.sv
hdl/sipd_ctrl.sv
hdl/sipd_datapath.sv
hdl/signed_int_to_padded_decimal.sv
hdl/sipd_checker.sv
tb/tb_signed_int_to_padded_decimal.sv
